[design/dq_srch_pkg.sv]
// package for the double-ended queue with search
// holds sizes, opcode and status codes, and the beat structs
// no dependencies
`default_nettype none

package dq_srch_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic               found;
    logic [CNT_W-1:0]   count;
  } out_beat_t;

endpackage

`default_nettype wire

[design/double_ended_queue_with_search.sv]
// double-ended queue of signed 32-bit values in a circular buffer, with linear search
// uses dq_srch_pkg; one storage array with one write port and one registered read port
// push, clear and no-op go from S_EXEC to S_DONE; pop adds S_POP to capture the registered read
// search steps through S_SCAN with one compare per stored entry, stopping at the first match or the last entry
// one beat in flight; a new beat is taken while the previous result waits for the sink
// reset clears head, count and handshake state; the storage array is not cleared
`default_nettype none

module double_ended_queue_with_search (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire dq_srch_pkg::in_beat_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dq_srch_pkg::out_beat_t out_data_o
);
  import dq_srch_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POP  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]         op_q;
  logic signed [31:0] val_q;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] popped_q, popped_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               wr_en;

  logic in_acc, full, empty, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_data_i.opcode;
      val_q <= in_data_i.value;
    end
    status_q <= status_d;
    popped_q <= popped_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    popped_d    = popped_q;
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = head_q;
    rd_addr     = head_q + idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        popped_d = '0;
        found_d  = 1'b0;
        state_d  = S_DONE;
        priority if (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if (op_q == OP_PUSH_FRONT) begin
              wr_addr = head_q - 1'b1;
              head_d  = head_q - 1'b1;
            end else begin
              wr_addr = head_q + count_q[IDX_W-1:0];
            end
          end
        end else if (op_q == OP_POP_FRONT || op_q == OP_POP_BACK) begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_POP;
            if (op_q == OP_POP_FRONT) begin
              rd_addr = head_q;
              head_d  = head_q + 1'b1;
            end else begin
              rd_addr = head_q + count_q[IDX_W-1:0] - 1'b1;
            end
          end
        end else if (op_q == OP_SEARCH) begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            rd_addr = head_q;
            idx_d   = CNT_W'(1);
            state_d = S_SCAN;
          end
        end else if (op_q == OP_CLEAR) begin
          if (empty) begin
            status_d = ST_EMPTY;
          end
          count_d = '0;
          head_d  = '0;
        end else begin
          status_d = ST_OK;
        end
      end
      S_POP: begin
        popped_d = rdata_q;
        state_d  = S_DONE;
      end
      S_SCAN: begin
        if (rdata_q == val_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (idx_q == count_q) begin
          state_d = S_DONE;
        end else begin
          rd_addr = head_q + idx_q[IDX_W-1:0];
          idx_d   = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d.status       = status_q;
          out_d.popped_value = popped_q;
          out_d.found        = found_q;
          out_d.count        = count_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
